// ----- design/u8u16_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16 stream decoder.
package u8u16_pkg;

	// Job queue between the byte classifier and the unit emitter
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// UTF-8 byte classes and masks
	localparam logic [7:0] CONT_MASK    = 8'hC0;
	localparam logic [7:0] CONT_TAG     = 8'h80;
	localparam logic [7:0] LEAD2_MASK   = 8'hE0;
	localparam logic [7:0] LEAD2_TAG    = 8'hC0;
	localparam logic [7:0] LEAD3_MASK   = 8'hF0;
	localparam logic [7:0] LEAD3_TAG    = 8'hE0;
	localparam logic [7:0] LEAD4_MASK   = 8'hF8;
	localparam logic [7:0] LEAD4_TAG    = 8'hF0;

	// Surrogate pair construction
	localparam logic [20:0] SUPP_OFFSET  = 21'h10000;
	localparam logic [15:0] SURR_HI_BASE = 16'hD800;
	localparam logic [15:0] SURR_LO_BASE = 16'hDC00;

	// Width of a pending (incomplete) code point: at most 15 bits
	localparam int ACC_W = 15;

	// One queued job: one or two code units from a single input byte
	typedef struct packed {
		logic [15:0] unit0;
		logic [15:0] unit1;
		logic        pair;
	} u8u16_job_t;

	// Queue head status seen by the emitter
	typedef struct packed {
		logic       valid;
		u8u16_job_t job;
	} u8u16_head_t;

endpackage

// ----- design/u8u16_front.sv -----
// Byte classifier: tracks the pending sequence and builds emit jobs.
module u8u16_front import u8u16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  data_byte,
	output logic        push,
	output u8u16_job_t  job
);

	logic [1:0]       exp_q, exp_d;
	logic [ACC_W-1:0] accum_q, accum_d;
	logic             pend, cont, ascii;
	logic [20:0]      cp_full, cp_off;
	logic [15:0]      surr_hi, surr_lo;

	// Completed code point and its surrogate halves
	assign cp_full = {accum_q, data_byte[5:0]};
	assign cp_off  = cp_full - SUPP_OFFSET;
	assign surr_hi = SURR_HI_BASE + {5'd0, cp_off[20:10]};
	assign surr_lo = SURR_LO_BASE | {6'd0, cp_off[9:0]};

	// Classify the byte against the pending state
	always_comb begin
		pend    = (exp_q != 2'd0);
		cont    = ((data_byte & CONT_MASK) == CONT_TAG);
		ascii   = (data_byte != 8'd0) && !data_byte[7];
		exp_d   = exp_q;
		accum_d = accum_q;
		push    = 1'b0;
		job     = '0;
		if (pend && cont) begin
			exp_d   = exp_q - 2'd1;
			accum_d = cp_full[ACC_W-1:0];
			if (exp_q == 2'd1) begin
				push    = 1'b1;
				accum_d = '0;
				if (cp_full[20:16] != 5'd0) begin
					job.unit0 = surr_hi;
					job.unit1 = surr_lo;
					job.pair  = 1'b1;
				end else begin
					job.unit0 = cp_full[15:0];
				end
			end
		end else begin
			exp_d   = 2'd0;
			accum_d = '0;
			// new lead byte
			priority if ((data_byte & LEAD2_MASK) == LEAD2_TAG) begin
				accum_d = ACC_W'(data_byte[4:0]);
				exp_d   = 2'd1;
			end else if ((data_byte & LEAD3_MASK) == LEAD3_TAG) begin
				accum_d = ACC_W'(data_byte[3:0]);
				exp_d   = 2'd2;
			end else if ((data_byte & LEAD4_MASK) == LEAD4_TAG) begin
				accum_d = ACC_W'(data_byte[2:0]);
				exp_d   = 2'd3;
			end else begin
				exp_d = 2'd0;
			end
			// flush of a cut-short sequence, then plain ASCII
			if (pend) begin
				push      = 1'b1;
				job.unit0 = {1'b0, accum_q};
				if (ascii) begin
					job.unit1 = {8'd0, data_byte};
					job.pair  = 1'b1;
				end
			end else if (ascii) begin
				push      = 1'b1;
				job.unit0 = {8'd0, data_byte};
			end
		end
	end

	// Sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q   <= 2'd0;
			accum_q <= '0;
		end else if (take) begin
			exp_q   <= exp_d;
			accum_q <= accum_d;
		end
	end

endmodule

// ----- design/u8u16_queue.sv -----
// Short job queue between classifier and emitter.
module u8u16_queue import u8u16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  u8u16_job_t  push_job,
	input  logic        pop,
	output logic        full,
	output u8u16_head_t head
);

	u8u16_job_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.job   = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ----- design/u8u16_back.sv -----
// Unit emitter: splits jobs into code units behind an output register.
module u8u16_back import u8u16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  u8u16_head_t head,
	output logic        pop,
	output logic        unit_valid,
	input  logic        unit_stall,
	output logic [15:0] code_unit,
	output logic        last_in_run
);

	logic        phase_q;
	logic        out_valid_q;
	logic [15:0] unit_q;
	logic        last_q;
	logic        load, second;

	// Output register may take a new unit when empty or being drained
	assign load   = !out_valid_q || !unit_stall;
	assign second = head.job.pair && !phase_q;
	assign pop    = load && head.valid && !second;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= head.valid;
			if (head.valid) begin
				phase_q <= second;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load && head.valid) begin
			unit_q <= phase_q ? head.job.unit1 : head.job.unit0;
			last_q <= !second;
		end
	end

	assign unit_valid  = out_valid_q;
	assign code_unit   = unit_q;
	assign last_in_run = last_q;

endmodule

// ----- design/utf8_to_utf16_stream_decoder_unit.sv -----
// UTF-8 to UTF-16 stream decoder, top level.
//
// Byte channel: byte_valid / byte_stall carry one UTF-8 byte (data_byte)
// per transfer. A zero byte ends the text and flushes any pending sequence.
// Unit channel: unit_valid / unit_stall carry one UTF-16 code unit
// (code_unit) per transfer; last_in_run marks the final unit produced by
// a byte. Bytes that produce nothing (leads, inner continuations, stray
// bytes, F8-FF, zero with nothing pending) give no transfer.
// Throughput: one byte per cycle while byte_stall is low; a byte producing two units (surrogate
// pair, or flush followed by ASCII) holds the emitter until both units are sent.
// Each unit passes through the job queue and then the output register.
// A four-entry job queue separates the classifier from the emitter, so the
// byte side keeps running while the receiver stalls, until the queue fills;
// byte_stall is then raised. A stalled unit is held unchanged.
// Reset clears the pending sequence, the queue and the output register.
module utf8_to_utf16_stream_decoder_unit import u8u16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	output logic        unit_valid,
	input  logic        unit_stall,
	output logic [15:0] code_unit,
	output logic        last_in_run
);

	logic        take, push, pop, full;
	u8u16_job_t  job;
	u8u16_head_t head;

	assign byte_stall = full;
	assign take       = byte_valid && !full;

	u8u16_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.push      (push),
		.job       (job)
	);

	u8u16_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push && take),
		.push_job (job),
		.pop      (pop),
		.full     (full),
		.head     (head)
	);

	u8u16_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.unit_valid  (unit_valid),
		.unit_stall  (unit_stall),
		.code_unit   (code_unit),
		.last_in_run (last_in_run)
	);

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the UTF-8 to UTF-16 stream decoder.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Surrogate construction, held locally so the predictor stands apart from the design
	localparam logic [20:0] PLANE1_BASE = 21'h10000;
	localparam logic [15:0] HI_SURR     = 16'hD800;
	localparam logic [15:0] LO_SURR     = 16'hDC00;
	localparam int          HOLD_CYCLES = 120;
	localparam int          LIVE_TARGET = 1650;
	localparam int          N_DIRECTED  = 25;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        byte_valid  = 1'b0;
	logic [7:0]  data_byte   = 8'h00;
	logic        unit_stall  = 1'b0;
	logic        byte_stall;
	logic        unit_valid;
	logic [15:0] code_unit;
	logic        last_in_run;

	typedef struct packed {
		logic [15:0] cu;
		logic        last;
	} unit_exp_t;

	// One directed row; typed rows carry their own answer, the rest use the predictor
	typedef struct {
		logic [7:0]  b;
		bit          typed;
		int          n;
		logic [15:0] u0;
		logic [15:0] u1;
	} dir_row_t;

	unit_exp_t   units_due[$];
	unit_exp_t   step_units[$];
	logic [1:0]  cont_left   = 2'd0;
	logic [20:0] cp_gather   = 21'd0;
	int          idle_pct    = 28;
	bit          hold_req    = 1'b0;
	int          errors      = 0;
	int          bytes_sent  = 0;
	int          live_bytes  = 0;
	int          units_checked = 0;
	int          surr_pairs  = 0;
	int          cut_short   = 0;

	dir_row_t dir_rows [N_DIRECTED] = '{
		'{8'h00, 1'b1, 0, 16'h0000, 16'h0000},	// end of text with nothing pending
		'{8'h41, 1'b1, 1, 16'h0041, 16'h0000},
		'{8'h7F, 1'b1, 1, 16'h007F, 16'h0000},
		'{8'h80, 1'b1, 0, 16'h0000, 16'h0000},	// stray continuation
		'{8'hF8, 1'b1, 0, 16'h0000, 16'h0000},	// illegal lead, skipped
		'{8'hFF, 1'b1, 0, 16'h0000, 16'h0000},
		'{8'hC3, 1'b1, 0, 16'h0000, 16'h0000},
		'{8'hA9, 1'b1, 1, 16'h00E9, 16'h0000},
		'{8'hE2, 1'b1, 0, 16'h0000, 16'h0000},
		'{8'h82, 1'b1, 0, 16'h0000, 16'h0000},
		'{8'hAC, 1'b1, 1, 16'h20AC, 16'h0000},
		'{8'hF0, 1'b1, 0, 16'h0000, 16'h0000},
		'{8'h9F, 1'b1, 0, 16'h0000, 16'h0000},
		'{8'h98, 1'b1, 0, 16'h0000, 16'h0000},
		'{8'h80, 1'b1, 2, 16'hD83D, 16'hDE00},	// surrogate pair
		'{8'hF7, 1'b0, 0, 16'h0000, 16'h0000},	// largest four-byte form, no range check
		'{8'hBF, 1'b0, 0, 16'h0000, 16'h0000},
		'{8'hBF, 1'b0, 0, 16'h0000, 16'h0000},
		'{8'hBF, 1'b0, 0, 16'h0000, 16'h0000},
		'{8'hC5, 1'b0, 0, 16'h0000, 16'h0000},	// cut short by ASCII: flush then unit
		'{8'h41, 1'b0, 0, 16'h0000, 16'h0000},
		'{8'hE1, 1'b0, 0, 16'h0000, 16'h0000},	// cut short by end of text
		'{8'h00, 1'b0, 0, 16'h0000, 16'h0000},
		'{8'hF4, 1'b0, 0, 16'h0000, 16'h0000},	// cut short by a skipped byte
		'{8'hFF, 1'b0, 0, 16'h0000, 16'h0000}
	};

	utf8_to_utf16_stream_decoder_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.data_byte   (data_byte),
		.unit_valid  (unit_valid),
		.unit_stall  (unit_stall),
		.code_unit   (code_unit),
		.last_in_run (last_in_run)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Turn a code point into one unit or a high/low surrogate pair
	function automatic void emit_code_point(input logic [20:0] cp);
		logic [20:0] off;
		if (cp <= 21'h00FFFF) begin
			step_units.insert(step_units.size(), '{cu: cp[15:0], last: 1'b0});
		end else begin
			off = cp - PLANE1_BASE;
			step_units.insert(step_units.size(),
				'{cu: HI_SURR + 16'(off[20:10]), last: 1'b0});
			step_units.insert(step_units.size(),
				'{cu: LO_SURR + 16'(off[9:0]), last: 1'b0});
			surr_pairs++;
		end
	endfunction

	// Decoder model: advances the pending sequence and fills step_units for one byte
	function automatic void decode_byte(input logic [7:0] b);
		bit was_pending;
		bit taken;
		was_pending = (cont_left != 2'd0);
		taken = 1'b0;
		step_units.delete();
		if (was_pending) begin
			if (b[7:6] == 2'b10) begin
				cp_gather = {cp_gather[14:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 2'd0) begin
					emit_code_point(cp_gather);
					cp_gather = 21'd0;
				end
				taken = 1'b1;
			end else begin
				// sequence broken off: flush the partial value, then treat b afresh
				emit_code_point(cp_gather);
				cut_short++;
				cont_left = 2'd0;
				cp_gather = 21'd0;
			end
		end
		if (!taken) begin
			if (b == 8'h00) begin
				// end of text, nothing more to do
			end else if (!b[7]) begin
				emit_code_point({13'd0, b});
			end else if (b[7:5] == 3'b110) begin
				cp_gather = {16'd0, b[4:0]};
				cont_left = 2'd1;
			end else if (b[7:4] == 4'b1110) begin
				cp_gather = {17'd0, b[3:0]};
				cont_left = 2'd2;
			end else if (b[7:3] == 5'b11110) begin
				cp_gather = {18'd0, b[2:0]};
				cont_left = 2'd3;
			end
		end
		if (step_units.size() != 0)
			step_units[step_units.size() - 1].last = 1'b1;
		if (was_pending || cont_left != 2'd0 || step_units.size() != 0)
			live_bytes++;
	endfunction

	// Present one byte, with random gaps before it, and wait for its transfer
	task automatic offer_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte  <= b;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic feed_byte(input logic [7:0] b);
		decode_byte(b);
		foreach (step_units[i])
			units_due.insert(units_due.size(), step_units[i]);
		offer_byte(b);
	endtask

	function automatic logic [7:0] lead_for(input int len);
		case (len)
			2: begin
				return {3'b110, 5'($urandom)};
			end
			3: begin
				return {4'b1110, 4'($urandom)};
			end
			default: begin
				return {5'b11110, 3'($urandom)};
			end
		endcase
	endfunction

	// Mostly well-formed sequences with random payload, plus truncations and noise
	task automatic send_random_sequence();
		int pick;
		int len;
		int cont_n;
		pick = $urandom_range(99);
		if (pick < 30) begin
			feed_byte(8'($urandom_range(127, 1)));
		end else if (pick < 80) begin
			len = (pick < 50) ? 2 : (pick < 65) ? 3 : 4;
			feed_byte(lead_for(len));
			repeat (len - 1) feed_byte({2'b10, 6'($urandom)});
		end else if (pick < 88) begin
			len = $urandom_range(4, 2);
			cont_n = $urandom_range(len - 2, 0);
			feed_byte(lead_for(len));
			repeat (cont_n) feed_byte({2'b10, 6'($urandom)});
		end else if (pick < 94) begin
			feed_byte(8'h00);
		end else if (pick < 97) begin
			feed_byte(8'($urandom));
		end else if (pick < 99) begin
			feed_byte({2'b10, 6'($urandom)});
		end else begin
			feed_byte({5'b11111, 3'($urandom)});
		end
	endtask

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				unit_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			unit_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// Check each unit transfer against the oldest expectation
	always @(posedge clk) begin : check_units
		unit_exp_t want;
		if (arst_n && unit_valid && !unit_stall) begin
			if (units_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected code unit, expected none got %h (last %b)",
					$time, code_unit, last_in_run);
			end else begin
				want = units_due.pop_front();
				units_checked++;
				if (code_unit !== want.cu) begin
					errors++;
					$display("%0t: code_unit expected %h got %h", $time, want.cu, code_unit);
				end
				if (last_in_run !== want.last) begin
					errors++;
					$display("%0t: last_in_run expected %b got %b (unit %h)",
						$time, want.last, last_in_run, want.cu);
				end
			end
		end
	end

	// Main sequence
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[i]) begin
			decode_byte(dir_rows[i].b);
			if (dir_rows[i].typed) begin
				if (dir_rows[i].n >= 1)
					units_due.insert(units_due.size(),
						'{cu: dir_rows[i].u0, last: dir_rows[i].n == 1});
				if (dir_rows[i].n == 2)
					units_due.insert(units_due.size(),
						'{cu: dir_rows[i].u1, last: 1'b1});
			end else begin
				foreach (step_units[j])
					units_due.insert(units_due.size(), step_units[j]);
			end
			offer_byte(dir_rows[i].b);
		end

		// random part: a quiet stretch, then a long receiver hold-off while bytes keep coming
		while (live_bytes < LIVE_TARGET) begin
			idle_pct = ((live_bytes >= 600 && live_bytes < 800) ||
				(live_bytes >= 1000 && live_bytes < 1080)) ? 0 : 28;
			if (!hold_done && live_bytes >= 1000) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			send_random_sequence();
		end
		byte_valid <= 1'b0;

		while (units_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d bytes (%0d with effect), %0d code units checked",
			bytes_sent, live_bytes, units_checked);
		$display("seen %0d surrogate pairs and %0d cut-short sequences, incl. a %0d-cycle hold-off",
			surr_pairs, cut_short, HOLD_CYCLES);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("%0t: timeout with %0d units outstanding", $time, units_due.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
